### rtl/core/julia_escape_time_assert.svh
// Assertion macros shared by the Julia escape-time RTL.
`ifndef JULIA_ESCAPE_TIME_ASSERT_SVH
`define JULIA_ESCAPE_TIME_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define JET_ASSERT_IMPL(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define JET_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

### rtl/core/jet_pkg.sv
// Types, constants and helper functions of the Julia escape-time engine.
`timescale 1ns / 1ps
`default_nettype none

package jet_pkg;

    localparam int COORD_BITS    = 11;
    localparam int ITER_BITS     = 10;
    localparam int FRAC_BITS_DEF = 24;
    localparam int STEP_BITS     = 31;
    localparam int ADDR_BITS     = 5;

    localparam logic [ITER_BITS-1:0] RST_MAX_ITER     = 10'd100;
    localparam logic signed [31:0]   RST_PLANE_MIN    = -32'sd20132659;
    localparam logic [STEP_BITS-1:0] RST_STEP_X       = 31'd39322;
    localparam logic [STEP_BITS-1:0] RST_STEP_Y       = 31'd39322;
    localparam logic signed [31:0]   RST_CONST_RE     = 32'sd4781507;
    localparam logic signed [31:0]   RST_CONST_IM     = 32'sd167772;
    localparam logic [STEP_BITS-1:0] RST_ESCAPE_LIMIT = 31'd268435456;

    typedef enum logic [2:0] {
        REG_MAX_ITER     = 3'd0,
        REG_PLANE_MIN    = 3'd1,
        REG_STEP_X       = 3'd2,
        REG_STEP_Y       = 3'd3,
        REG_CONST_RE     = 3'd4,
        REG_CONST_IM     = 3'd5,
        REG_ESCAPE_LIMIT = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_MUL,
        ST_TEST
    } t_state;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic [ITER_BITS-1:0]  iter_count;
        logic                  bounded;
    } t_result;

    typedef struct packed {
        logic [ITER_BITS-1:0]  max_iterations;
        logic signed [31:0]    plane_min;
        logic [STEP_BITS-1:0]  step_x;
        logic [STEP_BITS-1:0]  step_y;
        logic signed [31:0]    const_re;
        logic signed [31:0]    const_im;
        logic [STEP_BITS-1:0]  escape_limit;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic init;
        logic mul;
        logic update;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic limit_hit;
        logic escaped;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/julia_escape_time.sv
// Top level of the Julia escape-time engine: register file, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// A pixel beat is taken when start is high and busy is low. The pixel is mapped to the
// complex plane and z = z*z + c is iterated; each iteration is a multiply step followed
// by an add, compare and saturate step. The result appears when the iteration limit
// ends the loop or the point escapes; busy falls as the result appears, so a new pixel
// may be accepted at the edge that ends the result cycle. The result is shown for
// exactly one cycle with o_done high and must be taken then: the block has no way to
// hold it. The user must write the registers over the APB port only while the block is
// idle; the block itself does not enforce this.
module julia_escape_time #(
    parameter int FRAC_BITS = jet_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire jet_pkg::t_pixel               i_pixel,
    output logic                               o_done,
    output jet_pkg::t_result                   o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [jet_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    jet_pkg::t_cfg    r_cfg;
    jet_pkg::t_cmd    w_cmd;
    jet_pkg::t_status w_status;
    jet_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = jet_pkg::t_reg_idx'(paddr[jet_pkg::ADDR_BITS-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iterations <= jet_pkg::RST_MAX_ITER;
            r_cfg.plane_min      <= jet_pkg::RST_PLANE_MIN;
            r_cfg.step_x         <= jet_pkg::RST_STEP_X;
            r_cfg.step_y         <= jet_pkg::RST_STEP_Y;
            r_cfg.const_re       <= jet_pkg::RST_CONST_RE;
            r_cfg.const_im       <= jet_pkg::RST_CONST_IM;
            r_cfg.escape_limit   <= jet_pkg::RST_ESCAPE_LIMIT;
        end else if (w_wr) begin
            unique case (w_idx)
                jet_pkg::REG_MAX_ITER:     r_cfg.max_iterations <= pwdata[jet_pkg::ITER_BITS-1:0];
                jet_pkg::REG_PLANE_MIN:    r_cfg.plane_min      <= pwdata;
                jet_pkg::REG_STEP_X:       r_cfg.step_x         <= pwdata[jet_pkg::STEP_BITS-1:0];
                jet_pkg::REG_STEP_Y:       r_cfg.step_y         <= pwdata[jet_pkg::STEP_BITS-1:0];
                jet_pkg::REG_CONST_RE:     r_cfg.const_re       <= pwdata;
                jet_pkg::REG_CONST_IM:     r_cfg.const_im       <= pwdata;
                jet_pkg::REG_ESCAPE_LIMIT: r_cfg.escape_limit   <= pwdata[jet_pkg::STEP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            jet_pkg::REG_MAX_ITER:     prdata = 32'(r_cfg.max_iterations);
            jet_pkg::REG_PLANE_MIN:    prdata = r_cfg.plane_min;
            jet_pkg::REG_STEP_X:       prdata = 32'(r_cfg.step_x);
            jet_pkg::REG_STEP_Y:       prdata = 32'(r_cfg.step_y);
            jet_pkg::REG_CONST_RE:     prdata = r_cfg.const_re;
            jet_pkg::REG_CONST_IM:     prdata = r_cfg.const_im;
            jet_pkg::REG_ESCAPE_LIMIT: prdata = 32'(r_cfg.escape_limit);
            default:                   prdata = '0;
        endcase
    end

    jet_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    jet_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pixel  (i_pixel),
        .i_cfg    (r_cfg),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule

`default_nettype wire

### rtl/core/jet_dpath.sv
// Datapath of the Julia escape-time engine: start mapping, complex squaring, escape test.
`timescale 1ns / 1ps
`default_nettype none

module jet_dpath #(
    parameter int FRAC_BITS = jet_pkg::FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire jet_pkg::t_pixel  i_pixel,
    input  wire jet_pkg::t_cfg    i_cfg,
    input  wire jet_pkg::t_cmd    i_cmd,
    output jet_pkg::t_status      o_status,
    output jet_pkg::t_result      o_result,
    output logic                  o_done
);

    `include "julia_escape_time_assert.svh"

    localparam int CW       = jet_pkg::ITER_BITS;
    localparam int MAP_BITS = jet_pkg::COORD_BITS + jet_pkg::STEP_BITS;

    logic [jet_pkg::COORD_BITS-1:0] r_px;
    logic [jet_pkg::COORD_BITS-1:0] r_py;
    logic [MAP_BITS-1:0]            r_mx;
    logic [MAP_BITS-1:0]            r_my;
    logic signed [31:0]             r_zx;
    logic signed [31:0]             r_zy;
    logic [62:0]                    r_sx;
    logic [62:0]                    r_sy;
    logic [62:0]                    r_xy;
    logic [CW-1:0]                  r_count;
    jet_pkg::t_result               r_res;
    logic                           r_res_valid;

    logic signed [63:0] w_start_x;
    logic signed [63:0] w_start_y;
    logic signed [63:0] w_sq_x;
    logic signed [63:0] w_sq_y;
    logic signed [63:0] w_prod_xy;
    logic [63:0]        w_sum;
    logic [63:0]        w_bound;
    logic signed [63:0] w_diff;
    logic signed [63:0] w_re_sh;
    logic signed [63:0] w_xy_ext;
    logic signed [63:0] w_im_sh;
    logic signed [63:0] w_re;
    logic signed [63:0] w_im;

    assign w_start_x = {{32{i_cfg.plane_min[31]}}, i_cfg.plane_min}
                     + {{(64-MAP_BITS){1'b0}}, r_mx};
    assign w_start_y = {{32{i_cfg.plane_min[31]}}, i_cfg.plane_min}
                     + {{(64-MAP_BITS){1'b0}}, r_my};

    assign w_sq_x    = r_zx * r_zx;
    assign w_sq_y    = r_zy * r_zy;
    assign w_prod_xy = r_zx * r_zy;

    assign w_sum   = {1'b0, r_sx} + {1'b0, r_sy};
    assign w_bound = 64'(i_cfg.escape_limit) << FRAC_BITS;

    assign w_diff   = {1'b0, r_sx} - {1'b0, r_sy};
    assign w_re_sh  = w_diff >>> FRAC_BITS;
    assign w_xy_ext = {r_xy[62], r_xy};
    assign w_im_sh  = w_xy_ext >>> (FRAC_BITS - 1);
    assign w_re     = w_re_sh + {{32{i_cfg.const_re[31]}}, i_cfg.const_re};
    assign w_im     = w_im_sh + {{32{i_cfg.const_im[31]}}, i_cfg.const_im};

    assign o_status.limit_hit = (r_count == i_cfg.max_iterations);
    assign o_status.escaped   = (w_sum >= w_bound);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel.pixel_x;
            r_py <= i_pixel.pixel_y;
            r_mx <= MAP_BITS'(i_pixel.pixel_x) * MAP_BITS'(i_cfg.step_x);
            r_my <= MAP_BITS'(i_pixel.pixel_y) * MAP_BITS'(i_cfg.step_y);
        end
        if (i_cmd.init) begin
            r_zx    <= jet_pkg::sat32(w_start_x);
            r_zy    <= jet_pkg::sat32(w_start_y);
            r_count <= '0;
        end
        if (i_cmd.mul) begin
            r_sx <= w_sq_x[62:0];
            r_sy <= w_sq_y[62:0];
            r_xy <= w_prod_xy[62:0];
        end
        if (i_cmd.update) begin
            r_zx    <= jet_pkg::sat32(w_re);
            r_zy    <= jet_pkg::sat32(w_im);
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.finish) begin
            r_res.out_x      <= r_px;
            r_res.out_y      <= r_py;
            r_res.iter_count <= r_count;
            r_res.bounded    <= o_status.limit_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.finish;
        end
    end

    assign o_result = r_res;
    assign o_done   = r_res_valid;

    `JET_ASSERT_NEXT(a_count_step, i_cmd.update,
        (r_count == CW'($past(r_count) + 1'b1)), "iteration count did not advance by one")

endmodule

`default_nettype wire

### rtl/core/jet_ctrl.sv
// Controller state machine of the Julia escape-time engine.
`timescale 1ns / 1ps
`default_nettype none

module jet_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire jet_pkg::t_status i_status,
    output jet_pkg::t_cmd         o_cmd,
    output logic                  o_busy
);

    `include "julia_escape_time_assert.svh"

    jet_pkg::t_state r_state;
    jet_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jet_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            jet_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = jet_pkg::ST_INIT;
                end
            end
            jet_pkg::ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = jet_pkg::ST_MUL;
            end
            jet_pkg::ST_MUL: begin
                if (i_status.limit_hit) begin
                    o_cmd.finish = 1'b1;
                    n_state      = jet_pkg::ST_IDLE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = jet_pkg::ST_TEST;
                end
            end
            jet_pkg::ST_TEST: begin
                if (i_status.escaped) begin
                    o_cmd.finish = 1'b1;
                    n_state      = jet_pkg::ST_IDLE;
                end else begin
                    o_cmd.update = 1'b1;
                    n_state      = jet_pkg::ST_MUL;
                end
            end
            default: begin
                n_state = jet_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != jet_pkg::ST_IDLE);

    `JET_ASSERT_NEXT(a_start_init, (r_state == jet_pkg::ST_IDLE && i_start),
        (r_state == jet_pkg::ST_INIT), "accepted beat did not start the mapping")
    `JET_ASSERT_NEXT(a_finish_idle, o_cmd.finish,
        (r_state == jet_pkg::ST_IDLE), "controller did not return to idle after a result")
    `JET_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(o_cmd),
        "more than one datapath command issued at once")

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the Julia escape-time pixel engine.
`timescale 1ns / 1ps

module tb_top;

    localparam int                   FRAC          = jet_pkg::FRAC_BITS_DEF;
    localparam int                   COORD_W       = jet_pkg::COORD_BITS;
    localparam int                   ITER_W        = jet_pkg::ITER_BITS;
    localparam int                   STEP_W        = jet_pkg::STEP_BITS;
    localparam logic [COORD_W-1:0]   COORD_MAX     = '1;
    localparam logic [ITER_W-1:0]    ITER_MAX      = '1;
    localparam int                   SETTING_BEATS = 33;
    localparam int                   DRAIN_CYCLES  = 20;
    localparam int                   CYCLE_LIMIT   = 4000000;
    localparam longint               Q_MAX         = 64'sd2147483647;
    localparam longint               Q_MIN         = -64'sd2147483648;
    localparam logic [31:0]          INT_MAX32     = 32'h7FFFFFFF;
    localparam logic [31:0]          INT_MIN32     = 32'h80000000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    jet_pkg::t_pixel               i_pixel = '0;
    logic                          o_done;
    jet_pkg::t_result              o_result;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [jet_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    logic [ITER_W-1:0]  m_max_iter;
    logic signed [31:0] m_plane_min;
    logic [STEP_W-1:0]  m_step_x;
    logic [STEP_W-1:0]  m_step_y;
    logic signed [31:0] m_const_re;
    logic signed [31:0] m_const_im;
    logic [STEP_W-1:0]  m_escape_limit;

    jet_pkg::t_result pixel_results_due[$];
    int unsigned      send_idle_pct = 0;
    int unsigned      error_count = 0;
    int unsigned      pixels_sent = 0;
    int unsigned      results_checked = 0;
    int unsigned      settings_applied = 0;
    int unsigned      deepest_count = 0;
    int unsigned      cycle_count = 0;

    julia_escape_time dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_pixel  (i_pixel),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("julia_escape_time verification failed");
            $finish;
        end
    end

    function automatic longint clamp_q824(input longint v);
        if (v > Q_MAX) begin
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic jet_pkg::t_result escape_time_of(input logic [COORD_W-1:0] px,
                                                        input logic [COORD_W-1:0] py);
        longint            zx, zy, sx, sy, xy;
        longint            base, c_re, c_im, coord_x, coord_y, dx, dy;
        longint unsigned   mag, bound;
        int unsigned       count;
        jet_pkg::t_result  r;
        base    = longint'(m_plane_min);
        c_re    = longint'(m_const_re);
        c_im    = longint'(m_const_im);
        coord_x = 64'(px);
        coord_y = 64'(py);
        dx      = 64'(m_step_x);
        dy      = 64'(m_step_y);
        bound   = 64'(m_escape_limit);
        bound   = bound << FRAC;
        zx      = clamp_q824(base + coord_x * dx);
        zy      = clamp_q824(base + coord_y * dy);
        count   = 0;
        while (count < m_max_iter) begin
            sx  = zx * zx;
            sy  = zy * zy;
            mag = $unsigned(sx) + $unsigned(sy);
            if (mag >= bound) begin
                break;
            end
            xy = zx * zy;
            zx = clamp_q824(((sx - sy) >>> FRAC) + c_re);
            zy = clamp_q824((xy >>> (FRAC - 1)) + c_im);
            count++;
        end
        r.out_x      = px;
        r.out_y      = py;
        r.iter_count = count[ITER_W-1:0];
        r.bounded    = (count == m_max_iter);
        return r;
    endfunction

    function automatic logic [31:0] reg_value(input jet_pkg::t_reg_idx idx);
        case (idx)
            jet_pkg::REG_MAX_ITER:  return {{(32-ITER_W){1'b0}}, m_max_iter};
            jet_pkg::REG_PLANE_MIN: return m_plane_min;
            jet_pkg::REG_STEP_X:    return {1'b0, m_step_x};
            jet_pkg::REG_STEP_Y:    return {1'b0, m_step_y};
            jet_pkg::REG_CONST_RE:  return m_const_re;
            jet_pkg::REG_CONST_IM:  return m_const_im;
            default:                return {1'b0, m_escape_limit};
        endcase
    endfunction

    function automatic logic [31:0] reg_mask(input jet_pkg::t_reg_idx idx);
        case (idx) inside
            jet_pkg::REG_MAX_ITER: return 32'(ITER_MAX);
            jet_pkg::REG_STEP_X, jet_pkg::REG_STEP_Y, jet_pkg::REG_ESCAPE_LIMIT:
                return INT_MAX32;
            default:               return 32'hFFFFFFFF;
        endcase
    endfunction

    function automatic void set_model_reg(input jet_pkg::t_reg_idx idx, input logic [31:0] v);
        case (idx)
            jet_pkg::REG_MAX_ITER:  m_max_iter     = v[ITER_W-1:0];
            jet_pkg::REG_PLANE_MIN: m_plane_min    = v;
            jet_pkg::REG_STEP_X:    m_step_x       = v[STEP_W-1:0];
            jet_pkg::REG_STEP_Y:    m_step_y       = v[STEP_W-1:0];
            jet_pkg::REG_CONST_RE:  m_const_re     = v;
            jet_pkg::REG_CONST_IM:  m_const_im     = v;
            default:                m_escape_limit = v[STEP_W-1:0];
        endcase
    endfunction

    function automatic jet_pkg::t_cfg reset_cfg();
        jet_pkg::t_cfg c;
        c.max_iterations = jet_pkg::RST_MAX_ITER;
        c.plane_min      = jet_pkg::RST_PLANE_MIN;
        c.step_x         = jet_pkg::RST_STEP_X;
        c.step_y         = jet_pkg::RST_STEP_Y;
        c.const_re       = jet_pkg::RST_CONST_RE;
        c.const_im       = jet_pkg::RST_CONST_IM;
        c.escape_limit   = jet_pkg::RST_ESCAPE_LIMIT;
        return c;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        if ($urandom_range(15) == 0) begin
            return $urandom_range(1) ? COORD_MAX : '0;
        end
        return COORD_W'($urandom_range(COORD_MAX));
    endfunction

    function automatic jet_pkg::t_cfg pick_setting(input int mode, input int slot);
        jet_pkg::t_cfg c;
        logic [31:0]   raw;
        c = reset_cfg();
        c.plane_min      = -int'($urandom_range(20132659, 33554432));
        c.step_x         = STEP_W'($urandom_range(19661, 32768));
        c.step_y         = STEP_W'($urandom_range(19661, 32768));
        c.const_re       = int'($urandom_range(0, 33554432)) - 16777216;
        c.const_im       = int'($urandom_range(0, 33554432)) - 16777216;
        c.escape_limit   = $urandom_range(1) ? 31'd67108864 : jet_pkg::RST_ESCAPE_LIMIT;
        c.max_iterations = ITER_W'($urandom_range(16, 128));
        if (slot == 1) begin
            c.max_iterations = (mode == 0) ? ITER_MAX : (mode == 1) ? ITER_W'(1) : ITER_W'(0);
        end else if (slot == 2) begin
            raw              = $urandom;
            c.escape_limit   = raw[STEP_W-1:0];
            c.max_iterations = ITER_W'($urandom_range(1, 255));
        end else if (slot == 3) begin
            c.plane_min      = $urandom;
            raw              = $urandom;
            c.step_x         = raw[STEP_W-1:0];
            raw              = $urandom;
            c.step_y         = raw[STEP_W-1:0];
            c.const_re       = $urandom;
            c.const_im       = $urandom;
            raw              = $urandom;
            c.escape_limit   = raw[STEP_W-1:0];
            c.max_iterations = ITER_W'($urandom_range(0, 255));
        end
        return c;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(negedge i_clk) begin : check_results
        jet_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (pixel_results_due.size() == 0) begin
                $error("result beat with no pixel outstanding: x %0d y %0d count %0d",
                       o_result.out_x, o_result.out_y, o_result.iter_count);
                error_count++;
            end else begin
                want = pixel_results_due.pop_front();
                check_field("out_x", 32'(want.out_x), 32'(o_result.out_x));
                check_field("out_y", 32'(want.out_y), 32'(o_result.out_y));
                check_field("iter_count", 32'(want.iter_count), 32'(o_result.iter_count));
                check_field("bounded", 32'(want.bounded), 32'(o_result.bounded));
                results_checked++;
                if (o_result.iter_count > deepest_count) begin
                    deepest_count = 32'(o_result.iter_count);
                end
            end
        end
    end

    task automatic send_pixel(input logic [COORD_W-1:0] px,
                              input logic [COORD_W-1:0] py);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pixel <= '{pixel_x: px, pixel_y: py};
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        pixel_results_due.push_back(escape_time_of(px, py));
        pixels_sent++;
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pixel_results_due.size() != 0);
    endtask

    task automatic apb_access(input jet_pkg::t_reg_idx idx, input bit wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        bit ready_seen;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready_seen = pready;
            rdata      = prdata;
            @(posedge i_clk);
        end while (!ready_seen);
    endtask

    task automatic write_reg(input jet_pkg::t_reg_idx idx, input logic [31:0] v);
        logic [31:0] unused;
        apb_access(idx, 1'b1, v, unused);
        set_model_reg(idx, v);
    endtask

    // Reads every register back, then leaves the bus idle.
    task automatic check_registers();
        jet_pkg::t_reg_idx idx;
        logic [31:0]       got;
        for (int i = 0; i <= int'(jet_pkg::REG_ESCAPE_LIMIT); i++) begin
            idx = jet_pkg::t_reg_idx'(i);
            apb_access(idx, 1'b0, '0, got);
            if ((got & reg_mask(idx)) != reg_value(idx)) begin
                $error("register %s readback mismatch: expected %0h, actual %0h",
                       idx.name(), reg_value(idx), got & reg_mask(idx));
                error_count++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input jet_pkg::t_cfg c);
        wait_for_results();
        write_reg(jet_pkg::REG_MAX_ITER, {{(32-ITER_W){1'b0}}, c.max_iterations});
        write_reg(jet_pkg::REG_PLANE_MIN, c.plane_min);
        write_reg(jet_pkg::REG_STEP_X, {1'b0, c.step_x});
        write_reg(jet_pkg::REG_STEP_Y, {1'b0, c.step_y});
        write_reg(jet_pkg::REG_CONST_RE, c.const_re);
        write_reg(jet_pkg::REG_CONST_IM, c.const_im);
        write_reg(jet_pkg::REG_ESCAPE_LIMIT, {1'b0, c.escape_limit});
        check_registers();
        settings_applied++;
    endtask

    task automatic test_register_reset();
        jet_pkg::t_cfg c;
        c = reset_cfg();
        m_max_iter     = c.max_iterations;
        m_plane_min    = c.plane_min;
        m_step_x       = c.step_x;
        m_step_y       = c.step_y;
        m_const_re     = c.const_re;
        m_const_im     = c.const_im;
        m_escape_limit = c.escape_limit;
        check_registers();
    endtask

    // Four corners and the plane origin at the reset window; the far corner starts escaped.
    task automatic test_reset_image();
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(COORD_MAX, 0);
        send_pixel(0, COORD_MAX);
        send_pixel(512, 512);
    endtask

    task automatic test_register_access();
        jet_pkg::t_cfg c;
        c.max_iterations = ITER_MAX;
        c.plane_min      = '1;
        c.step_x         = '1;
        c.step_y         = '1;
        c.const_re       = '1;
        c.const_im       = '1;
        c.escape_limit   = '1;
        apply_config(c);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(0, 0);
        apply_config('0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(0, 0);
    endtask

    task automatic test_special_cases();
        jet_pkg::t_cfg c;
        // Zero iteration limit: nothing runs and the point counts as bounded.
        c = reset_cfg();
        c.max_iterations = 0;
        apply_config(c);
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        // Zero escape limit: every point escapes before the first iteration.
        c = reset_cfg();
        c.escape_limit = 0;
        apply_config(c);
        send_pixel(1024, 1024);
        send_pixel(0, COORD_MAX);
        // Start mapping at both ends of the plane, saturating at the top.
        c = reset_cfg();
        c.plane_min = INT_MIN32;
        c.step_x    = 0;
        c.step_y    = 0;
        apply_config(c);
        send_pixel(COORD_MAX, 0);
        c.plane_min = INT_MAX32;
        c.step_x    = '1;
        apply_config(c);
        send_pixel(COORD_MAX, 0);
        // The origin with c at zero never leaves, so the full limit is reached.
        c = reset_cfg();
        c.max_iterations = ITER_MAX;
        c.plane_min      = 0;
        c.step_x         = 0;
        c.step_y         = 1;
        c.const_re       = 0;
        c.const_im       = 0;
        apply_config(c);
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        // Large squares plus an extreme c saturate the next z upward.
        c.plane_min    = 0;
        c.step_x       = 65536;
        c.step_y       = 65536;
        c.const_re     = INT_MAX32;
        c.const_im     = INT_MAX32;
        c.escape_limit = '1;
        apply_config(c);
        send_pixel(COORD_MAX, 0);
        send_pixel(1448, 1448);
        // A negative cross product plus the most negative c saturates downward.
        c.plane_min = -32'sd94896128;
        c.step_y    = 131072;
        c.const_re  = INT_MIN32;
        c.const_im  = INT_MIN32;
        apply_config(c);
        send_pixel(0, 1448);
    endtask

    task automatic test_random_traffic();
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 21 : (mode == 1) ? 67 : 0;
            for (int slot = 0; slot < 4; slot++) begin
                apply_config(pick_setting(mode, slot));
                repeat (SETTING_BEATS) send_pixel(pick_coord(), pick_coord());
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_reset();
        test_reset_image();
        test_register_access();
        test_special_cases();
        test_random_traffic();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pixel_results_due.size() != 0) begin
            $error("%0d pixel results never arrived", pixel_results_due.size());
            error_count++;
        end
        $display("Run covered %0d pixel beats and %0d result beats over %0d register settings.",
                 pixels_sent, results_checked, settings_applied);
        $display("Deepest escape count observed: %0d iterations.", deepest_count);
        if (error_count == 0) begin
            $display("julia_escape_time verification clean");
        end else begin
            $display("julia_escape_time verification failed");
        end
        $finish;
    end

endmodule
